FILE: rtl/ppps_pkg.sv
package ppps_pkg;

  // Field widths of the stream and the registers.
  localparam int POS_W    = 24;
  localparam int RAD_W    = 12;
  localparam int FORCE_W  = 16;
  localparam int GAIN_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // Internal datapath widths.
  localparam int D_W     = POS_W + 1;          // offset between two positions
  localparam int SQ_W    = 2 * D_W;            // sum of squares
  localparam int DQ_W    = D_W;                // distance, Q8
  localparam int DEN_W   = DQ_W + 1;           // distance plus one pixel
  localparam int PROD_W  = GAIN_W + FORCE_W;   // gain times force
  localparam int F_W     = 32;                 // force magnitude, Q8
  localparam int NUM_W   = F_W + D_W;          // force times offset
  localparam int ONE_PIX = 256;                // one pixel at Q8

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PULL_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULL_FORCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PUSH_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PUSH_FORCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

  typedef enum logic [1:0] {
    ZONE_NONE = 2'd0,
    ZONE_PULL = 2'd1,
    ZONE_PUSH = 2'd2
  } zone_t;

  // Items carried beside the square root.
  typedef struct packed {
    logic signed [POS_W-1:0] mx;
    logic signed [POS_W-1:0] my;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
  } sqrt_sb_t;

  // Items carried beside the force division.
  typedef struct packed {
    logic signed [POS_W-1:0] mx;
    logic signed [POS_W-1:0] my;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    logic [DQ_W-1:0]         dq;
    zone_t                   zone;
  } fdiv_sb_t;

  // Items carried beside the x step division.
  typedef struct packed {
    logic signed [POS_W-1:0] mx;
    logic                    neg;
    logic                    dq_zero;
    zone_t                   zone;
  } xdiv_sb_t;

  // Items carried beside the y step division.
  typedef struct packed {
    logic signed [POS_W-1:0] my;
    logic                    neg;
  } ydiv_sb_t;

endpackage

FILE: rtl/ppps_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ppps_sqrt #(
  parameter int OUT_W = ppps_pkg::DQ_W,
  parameter int SB_W  = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [2*OUT_W-1:0]   radicand,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_vld,
  output logic [OUT_W-1:0]     root,
  output logic [SB_W-1:0]      out_sb
);

  localparam int IN_W = 2 * OUT_W;
  localparam int RW   = OUT_W + 3;

  logic             vld_r  [0:OUT_W-1];
  logic [RW-1:0]    rem_r  [0:OUT_W-1];
  logic [OUT_W-1:0] root_r [0:OUT_W-1];
  logic [IN_W-1:0]  bits_r [0:OUT_W-1];
  logic [SB_W-1:0]  sb_r   [0:OUT_W-1];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic             vld_in;
    logic [RW-1:0]    rem_in;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  bits_in;
    logic [SB_W-1:0]  sb_in;
    logic [RW-1:0]    cur;
    logic [RW-1:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign bits_in = radicand;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign bits_in = bits_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign cur   = {rem_in[RW-3:0], bits_in[IN_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {root_in[OUT_W-2:0], ge};
        bits_r[k] <= {bits_in[IN_W-3:0], 2'b00};
        sb_r[k]   <= sb_in;
      end
    end
  end

  assign out_vld = vld_r[OUT_W-1];
  assign root    = root_r[OUT_W-1];
  assign out_sb  = sb_r[OUT_W-1];

endmodule

FILE: rtl/ppps_div.sv
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QUO_W bits; the divisor travels with each item.
module ppps_div #(
  parameter int NUM_W = ppps_pkg::NUM_W,
  parameter int DEN_W = ppps_pkg::DQ_W,
  parameter int QUO_W = ppps_pkg::F_W,
  parameter int SB_W  = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_vld,
  output logic [QUO_W-1:0]  quo,
  output logic [SB_W-1:0]   out_sb
);

  logic             vld_r [0:QUO_W-1];
  logic [DEN_W-1:0] rem_r [0:QUO_W-1];
  logic [DEN_W-1:0] den_r [0:QUO_W-1];
  logic [QUO_W-1:0] nq_r  [0:QUO_W-1];
  logic [SB_W-1:0]  sb_r  [0:QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] nq_in;
    logic [SB_W-1:0]  sb_in;
    logic [DEN_W:0]   cur;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = DEN_W'(num >> QUO_W);
      assign den_in = den;
      assign nq_in  = num[QUO_W-1:0];
      assign sb_in  = in_sb;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign sb_in  = sb_r[k-1];
    end

    // Shift in the next dividend bit and subtract where it fits.
    assign cur  = {rem_in, nq_in[QUO_W-1]};
    assign diff = cur - {1'b0, den_in};
    assign ge   = (cur >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
        den_r[k] <= den_in;
        nq_r[k]  <= {nq_in[QUO_W-2:0], ge};
        sb_r[k]  <= sb_in;
      end
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign quo     = nq_r[QUO_W-1];
  assign out_sb  = sb_r[QUO_W-1];

endmodule

FILE: rtl/particle_push_pull_step.sv
// One push/pull step per particle pair, fully pipelined: a new pair is taken
// every cycle while the output is not stalled. Each result passes through the
// 25-stage square root and the two chained 32-stage dividers (force, then
// per-axis step). A stall at the output freezes the whole pipeline. The
// registers on the configuration port must be written only while the block
// holds no item.
module particle_push_pull_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // moved_x, moved_y, source_x, source_y
  input  logic [4*ppps_pkg::POS_W-1:0]    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // new_x, new_y
  output logic [2*ppps_pkg::POS_W-1:0]    out_tdata,
  // zone
  output logic [1:0]                      out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppps_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int POS_W = ppps_pkg::POS_W;
  localparam int D_W   = ppps_pkg::D_W;
  localparam int SQ_W  = ppps_pkg::SQ_W;
  localparam int DQ_W  = ppps_pkg::DQ_W;
  localparam int F_W   = ppps_pkg::F_W;
  localparam int NUM_W = ppps_pkg::NUM_W;
  localparam int SUM_W = F_W + 2;

  logic en;

  // Configuration registers.
  logic [ppps_pkg::RAD_W-1:0]   pull_radius_r;
  logic [ppps_pkg::FORCE_W-1:0] pull_force_r;
  logic [ppps_pkg::RAD_W-1:0]   push_radius_r;
  logic [ppps_pkg::FORCE_W-1:0] push_force_r;
  logic [ppps_pkg::GAIN_W-1:0]  gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pull_radius_r <= '0;
      pull_force_r  <= '0;
      push_radius_r <= '0;
      push_force_r  <= '0;
      gain_r        <= ppps_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppps_pkg::CFG_PULL_RADIUS: pull_radius_r <= cfg_data[ppps_pkg::RAD_W-1:0];
        ppps_pkg::CFG_PULL_FORCE:  pull_force_r  <= cfg_data[ppps_pkg::FORCE_W-1:0];
        ppps_pkg::CFG_PUSH_RADIUS: push_radius_r <= cfg_data[ppps_pkg::RAD_W-1:0];
        ppps_pkg::CFG_PUSH_FORCE:  push_force_r  <= cfg_data[ppps_pkg::FORCE_W-1:0];
        ppps_pkg::CFG_GAIN:        gain_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register can take a beat.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: offsets from the moved particle to the source.
  logic                    vld1_r;
  logic signed [POS_W-1:0] mx1_r, my1_r;
  logic signed [D_W-1:0]   dx1_r, dy1_r;
  logic signed [POS_W-1:0] in_mx, in_my, in_sx, in_sy;

  assign in_mx = in_tdata[0*POS_W +: POS_W];
  assign in_my = in_tdata[1*POS_W +: POS_W];
  assign in_sx = in_tdata[2*POS_W +: POS_W];
  assign in_sy = in_tdata[3*POS_W +: POS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1_r <= in_mx;
      my1_r <= in_my;
      dx1_r <= {in_sx[POS_W-1], in_sx} - {in_mx[POS_W-1], in_mx};
      dy1_r <= {in_sy[POS_W-1], in_sy} - {in_my[POS_W-1], in_my};
    end
  end

  // Stage 2: squares of the offset magnitudes.
  logic [D_W-1:0]          ax1, ay1;
  logic                    vld2_r;
  logic [SQ_W-1:0]         sqx2_r, sqy2_r;
  logic signed [POS_W-1:0] mx2_r, my2_r;
  logic signed [D_W-1:0]   dx2_r, dy2_r;

  assign ax1 = dx1_r[D_W-1] ? D_W'(-dx1_r) : D_W'(dx1_r);
  assign ay1 = dy1_r[D_W-1] ? D_W'(-dy1_r) : D_W'(dy1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2_r <= SQ_W'(ax1) * SQ_W'(ax1);
      sqy2_r <= SQ_W'(ay1) * SQ_W'(ay1);
      mx2_r  <= mx1_r;
      my2_r  <= my1_r;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
    end
  end

  // Stage 3: squared distance.
  logic                  vld3_r;
  logic [SQ_W-1:0]       sum3_r;
  ppps_pkg::sqrt_sb_t    sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r   <= sqx2_r + sqy2_r;
      sb3_r.mx <= mx2_r;
      sb3_r.my <= my2_r;
      sb3_r.dx <= dx2_r;
      sb3_r.dy <= dy2_r;
    end
  end

  // Distance by square root.
  logic               sq_vld;
  logic [DQ_W-1:0]    sq_root;
  ppps_pkg::sqrt_sb_t sq_sb;

  ppps_sqrt #(
    .OUT_W (DQ_W),
    .SB_W  ($bits(ppps_pkg::sqrt_sb_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld3_r),
    .radicand (sum3_r),
    .in_sb    (sb3_r),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_sb   (sq_sb)
  );

  // Stage 4: zone choice, the force numerator and its denominator.
  logic [DQ_W-1:0]              push_q, pull_q;
  logic                         is_pull;
  logic                         is_push;
  logic [ppps_pkg::FORCE_W-1:0] force_sel;
  logic                         vld4_r;
  logic [ppps_pkg::PROD_W-1:0]  prod4_r;
  logic [ppps_pkg::DEN_W-1:0]   den4_r;
  ppps_pkg::fdiv_sb_t           sb4_r;

  assign push_q    = DQ_W'({push_radius_r, 8'h00});
  assign pull_q    = DQ_W'({pull_radius_r, 8'h00});
  assign is_pull   = (sq_root > push_q) && (sq_root < pull_q);
  assign is_push   = !is_pull && (sq_root <= push_q);
  assign force_sel = is_pull ? pull_force_r : push_force_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (en) begin
      vld4_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod4_r  <= ppps_pkg::PROD_W'(gain_r) * ppps_pkg::PROD_W'(force_sel);
      den4_r   <= ppps_pkg::DEN_W'(sq_root) + ppps_pkg::DEN_W'(ppps_pkg::ONE_PIX);
      sb4_r.mx <= sq_sb.mx;
      sb4_r.my <= sq_sb.my;
      sb4_r.dx <= sq_sb.dx;
      sb4_r.dy <= sq_sb.dy;
      sb4_r.dq <= sq_root;
      if (is_pull) begin
        sb4_r.zone <= ppps_pkg::ZONE_PULL;
      end else if (is_push) begin
        sb4_r.zone <= ppps_pkg::ZONE_PUSH;
      end else begin
        sb4_r.zone <= ppps_pkg::ZONE_NONE;
      end
    end
  end

  // Force magnitude: gain * force / (distance + one pixel).
  logic               fd_vld;
  logic [F_W-1:0]     fd_quo;
  ppps_pkg::fdiv_sb_t fd_sb;

  ppps_div #(
    .NUM_W (ppps_pkg::PROD_W),
    .DEN_W (ppps_pkg::DEN_W),
    .QUO_W (F_W),
    .SB_W  ($bits(ppps_pkg::fdiv_sb_t))
  ) u_fdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld4_r),
    .num     (prod4_r),
    .den     (den4_r),
    .in_sb   (sb4_r),
    .out_vld (fd_vld),
    .quo     (fd_quo),
    .out_sb  (fd_sb)
  );

  // Stage 5: force times each offset magnitude.
  logic [D_W-1:0]     ax4, ay4;
  logic               vld5_r;
  logic [NUM_W-1:0]   fx5_r, fy5_r;
  logic [DQ_W-1:0]    dq5_r;
  ppps_pkg::xdiv_sb_t xsb5_r;
  ppps_pkg::ydiv_sb_t ysb5_r;

  assign ax4 = fd_sb.dx[D_W-1] ? D_W'(-fd_sb.dx) : D_W'(fd_sb.dx);
  assign ay4 = fd_sb.dy[D_W-1] ? D_W'(-fd_sb.dy) : D_W'(fd_sb.dy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (en) begin
      vld5_r <= fd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx5_r          <= NUM_W'(fd_quo) * NUM_W'(ax4);
      fy5_r          <= NUM_W'(fd_quo) * NUM_W'(ay4);
      dq5_r          <= fd_sb.dq;
      xsb5_r.mx      <= fd_sb.mx;
      xsb5_r.neg     <= fd_sb.dx[D_W-1];
      xsb5_r.dq_zero <= (fd_sb.dq == '0);
      xsb5_r.zone    <= fd_sb.zone;
      ysb5_r.my      <= fd_sb.my;
      ysb5_r.neg     <= fd_sb.dy[D_W-1];
    end
  end

  // Per-axis step: force * |offset| / distance.
  logic               xd_vld;
  logic               yd_vld;
  logic [F_W-1:0]     xd_quo, yd_quo;
  ppps_pkg::xdiv_sb_t xd_sb;
  ppps_pkg::ydiv_sb_t yd_sb;

  ppps_div #(
    .NUM_W (NUM_W),
    .DEN_W (DQ_W),
    .QUO_W (F_W),
    .SB_W  ($bits(ppps_pkg::xdiv_sb_t))
  ) u_xdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld5_r),
    .num     (fx5_r),
    .den     (dq5_r),
    .in_sb   (xsb5_r),
    .out_vld (xd_vld),
    .quo     (xd_quo),
    .out_sb  (xd_sb)
  );

  ppps_div #(
    .NUM_W (NUM_W),
    .DEN_W (DQ_W),
    .QUO_W (F_W),
    .SB_W  ($bits(ppps_pkg::ydiv_sb_t))
  ) u_ydiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld5_r),
    .num     (fy5_r),
    .den     (dq5_r),
    .in_sb   (ysb5_r),
    .out_vld (yd_vld),
    .quo     (yd_quo),
    .out_sb  (yd_sb)
  );

  // Output stage: apply the signed step and clamp to the field range, or keep the position if it does not move.
  function automatic logic [POS_W-1:0] apply_step(
    input logic signed [POS_W-1:0] pos,
    input logic [F_W-1:0]          step,
    input logic                    neg
  );
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;
    delta = neg ? -$signed({2'b00, step}) : $signed({2'b00, step});
    sum   = SUM_W'(pos) + delta;
    if (sum > SUM_W'(ppps_pkg::POS_MAX)) begin
      return ppps_pkg::POS_MAX;
    end else if (sum < SUM_W'(ppps_pkg::POS_MIN)) begin
      return ppps_pkg::POS_MIN;
    end
    return sum[POS_W-1:0];
  endfunction

  logic               moves;
  logic               away;
  logic               out_vld_r;
  logic [POS_W-1:0]   new_x_r, new_y_r;
  ppps_pkg::zone_t    zone_r;

  assign moves = (xd_sb.zone != ppps_pkg::ZONE_NONE) && !xd_sb.dq_zero;
  assign away  = (xd_sb.zone == ppps_pkg::ZONE_PUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= xd_vld && yd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zone_r <= xd_sb.zone;
      if (moves) begin
        new_x_r <= apply_step(xd_sb.mx, xd_quo, xd_sb.neg ^ away);
        new_y_r <= apply_step(yd_sb.my, yd_quo, yd_sb.neg ^ away);
      end else begin
        new_x_r <= xd_sb.mx;
        new_y_r <= yd_sb.my;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {new_y_r, new_x_r};
  assign out_tuser  = zone_r;

endmodule
